FILE: hdl/lis_pkg.sv
`timescale 1ns / 1ps
// lis_pkg: shared widths and status types for the longest increasing subsequence block
// no dependencies; imported by the search, step, top level and checker modules

package lis_pkg;

  // width of the value field carried in the input beat
  localparam int IN_TDATA_W  = 32;
  // width of each length field in the result beat
  localparam int LEN_W       = 11;
  // result beat: end_length, best_length, overflow, padded to whole bytes
  localparam int OUT_TDATA_W = 24;

  // status handed from the search sequencer to the top level
  typedef struct packed {
    logic done;    // search finished, slot is valid this cycle
    logic append;  // slot equals the fill count, no entry was replaced
  } srch_stat_t;

endpackage

FILE: hdl/longest_increasing_subsequence_length_top.sv
`timescale 1ns / 1ps
// longest_increasing_subsequence_length_top: stream wrapper, fill count and result register
// search: the result beat follows the input beat after a binary search over the tails store,
//   one step per cycle on the tails memory port
// one beat at a time: the input stays closed until the result is registered; the result register
//   lets the next beat in while a result still waits downstream
// reset: synchronous rst_n clears the fill count, overflow flag and handshakes; no memory sweep

module longest_increasing_subsequence_length_top
  import lis_pkg::*;
#(
  parameter int MAX_LEN     = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [10:0] end_length, [21:11] best_length,
                                             // [22] overflow, [23] zero
  output logic                   out_tlast
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_PUT  = 2'd2;

  logic [1:0]             st_r, st_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ov_r, ov_nxt;
  logic [CNT_W-1:0]       end_r, end_nxt;
  logic                   last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                             in_fire;
  logic [VALUE_WIDTH+IN_TDATA_W-1:0] raw_ext;
  logic [VALUE_WIDTH-1:0]           key;
  srch_stat_t                       stat;
  logic [CNT_W-1:0]                 slot;
  logic                             sat;
  logic [CNT_W+LEN_W-1:0]           end_ext;
  logic [CNT_W+LEN_W-1:0]           best_ext;

  assign in_tready = (st_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // signed value to unsigned key of the same order: flip the sign bit
  assign raw_ext = {{VALUE_WIDTH{1'b0}}, in_tdata};
  assign key     = raw_ext[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  lis_search #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .count  (cnt_r),
    .key_in (key),
    .stat   (stat),
    .slot   (slot)
  );

  // length fields are reported modulo the 11 bit field
  assign end_ext  = {{LEN_W{1'b0}}, end_r};
  assign best_ext = {{LEN_W{1'b0}}, cnt_r};

  assign sat = stat.append && (cnt_r == CNT_W'(MAX_LEN));

  // item flow: accept, search, then hand the result to the output register
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    ov_nxt        = ov_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          last_nxt = in_tlast;
          st_nxt   = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (stat.done) begin
          end_nxt = sat ? CNT_W'(MAX_LEN) : (slot + CNT_W'(1));
          if (stat.append && !sat) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          ov_nxt = ov_r | sat;
          st_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, ov_r, best_ext[LEN_W-1:0], end_ext[LEN_W-1:0]};
          out_last_nxt  = last_r;
          if (last_r) begin
            cnt_nxt = '0;
            ov_nxt  = 1'b0;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      ov_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      ov_r        <= ov_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/lis_step.sv
`timescale 1ns / 1ps
// lis_step: one binary search step, the shared compare and bound update unit
// uses lis_pkg; instantiated by lis_search

module lis_step
  import lis_pkg::*;
#(
  parameter int CNT_W       = 11,
  parameter int VALUE_WIDTH = 32
) (
  input  logic [CNT_W-1:0]       lo,
  input  logic [CNT_W-1:0]       hi,
  input  logic [CNT_W-1:0]       mid,
  input  logic [VALUE_WIDTH-1:0] entry,
  input  logic [VALUE_WIDTH-1:0] key,
  output logic [CNT_W-1:0]       nlo,
  output logic [CNT_W-1:0]       nhi,
  output logic [CNT_W-1:0]       nmid,
  output logic                   more
);

  logic             less;
  logic [CNT_W-1:0] span;

  // entry below key moves the lower bound past mid, otherwise mid is the new upper bound
  always_comb begin
    less = (entry < key);
    nlo  = less ? (mid + CNT_W'(1)) : lo;
    nhi  = less ? hi : mid;
    span = nhi - nlo;
    nmid = nlo + (span >> 1);
    more = (nlo < nhi);
  end

endmodule

FILE: hdl/lis_search.sv
`timescale 1ns / 1ps
// lis_search: tails memory and the sequencer that binary searches and writes it back
// uses lis_pkg and lis_step; instantiated by the top level

module lis_search
  import lis_pkg::*;
#(
  parameter int MAX_LEN     = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [CNT_W-1:0]       count,
  input  logic [VALUE_WIDTH-1:0] key_in,
  output srch_stat_t             stat,
  output logic [CNT_W-1:0]       slot
);

  localparam int ADDR_W = $clog2(MAX_LEN);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CMP  = 1'b1;

  logic                   st_r, st_nxt;
  logic [CNT_W-1:0]       lo_r, lo_nxt;
  logic [CNT_W-1:0]       hi_r, hi_nxt;
  logic [CNT_W-1:0]       mid_r, mid_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                   empty_r, empty_nxt;

  logic [VALUE_WIDTH-1:0] tails_mem [MAX_LEN];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   we;
  logic                   fin;
  logic [CNT_W-1:0]       slot_val;

  logic [CNT_W-1:0]       nlo, nhi, nmid;
  logic                   more;

  // shared compare unit, used once per search step
  lis_step #(
    .CNT_W       (CNT_W),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .lo    (lo_r),
    .hi    (hi_r),
    .mid   (mid_r),
    .entry (rd_data_r),
    .key   (key_r),
    .nlo   (nlo),
    .nhi   (nhi),
    .nmid  (nmid),
    .more  (more)
  );

  // sequencer: read at start unless empty, then one compare and one read per cycle
  always_comb begin
    st_nxt    = st_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    empty_nxt = empty_r;
    rd_en     = 1'b0;
    rd_addr   = mid_r[ADDR_W-1:0];
    fin       = 1'b0;
    slot_val  = lo_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = key_in;
          cnt_nxt   = count;
          lo_nxt    = '0;
          hi_nxt    = count;
          mid_nxt   = count >> 1;
          empty_nxt = (count == '0);
          rd_en     = (count != '0);
          rd_addr   = mid_nxt[ADDR_W-1:0];
          st_nxt    = S_CMP;
        end
      end
      S_CMP: begin
        if (empty_r) begin
          fin      = 1'b1;
          slot_val = lo_r;
          st_nxt   = S_IDLE;
        end else if (more) begin
          lo_nxt  = nlo;
          hi_nxt  = nhi;
          mid_nxt = nmid;
          rd_en   = 1'b1;
          rd_addr = nmid[ADDR_W-1:0];
        end else begin
          fin      = 1'b1;
          slot_val = nlo;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // write back unless the store is full and the key lies past every entry
  assign we          = fin && (slot_val != CNT_W'(MAX_LEN));
  assign stat.done   = fin;
  assign stat.append = (slot_val == cnt_r);
  assign slot        = slot_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    cnt_r   <= cnt_nxt;
    key_r   <= key_nxt;
    empty_r <= empty_nxt;
  end

  // tails store, one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= tails_mem[rd_addr];
    end
    if (we) begin
      tails_mem[slot_val[ADDR_W-1:0]] <= key_r;
    end
  end

endmodule

FILE: hdl/lis_checker.sv
`timescale 1ns / 1ps
// lis_checker: port level assertions for the longest increasing subsequence block
// uses lis_pkg; bound to longest_increasing_subsequence_length_top below

module lis_checker
  import lis_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  logic [LEN_W-1:0] end_len;
  logic [LEN_W-1:0] best_len;
  logic             ovf;

  assign end_len  = out_tdata[LEN_W-1:0];
  assign best_len = out_tdata[2*LEN_W-1:LEN_W];
  assign ovf      = out_tdata[2*LEN_W];

  // one item at a time: a taken beat closes input until its result is registered
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again right after a beat");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // lengths stay ordered and inside the store depth
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (MAX_LEN < 2048) |->
      end_len != '0 && end_len <= best_len && best_len <= LEN_W'(MAX_LEN))
    else $error("length fields out of range");

  // overflow only once the store has filled
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ovf |-> best_len == LEN_W'(MAX_LEN))
    else $error("overflow flagged with a store that is not full");

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

endmodule

bind longest_increasing_subsequence_length_top lis_checker #(
  .MAX_LEN (MAX_LEN)
) u_lis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
